FILE: hdl/lrni_pkg.sv
package lrni_pkg;

  localparam int DIV_STAGES = 16;
  localparam int DIV_LAT = DIV_STAGES + 1;
  localparam int SQ_STAGES = 8;
  localparam int SQ_LAT = SQ_STAGES + 1;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] acc;
    logic [31:0] dv;
    logic        neg;
    logic        zero;
  } div_st_t;

  typedef struct packed {
    logic [19:0] rem;
    logic [15:0] root;
    logic [31:0] val;
  } sq_st_t;

  typedef struct packed {
    logic        steep;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] left;
    logic [31:0] top;
    logic [31:0] right;
    logic [31:0] bottom;
    logic [31:0] m0;
    logic [31:0] m1;
  } side_t;

  typedef struct packed {
    logic [3:0][31:0] cx;
    logic [3:0][31:0] cy;
    logic [3:0]       mask;
  } cand_t;

endpackage

FILE: hdl/lrni_div.sv
module lrni_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);

  lrni_pkg::div_st_t st0;
  lrni_pkg::div_st_t stg [lrni_pkg::DIV_STAGES];

  function automatic lrni_pkg::div_st_t div_step(input lrni_pkg::div_st_t s);
    lrni_pkg::div_st_t r;
    r = s;
    for (int k = 0; k < 2; k++) begin
      r.rem = {r.rem[31:0], r.acc[31]};
      r.acc = {r.acc[30:0], 1'b0};
      if (r.rem >= {1'b0, r.dv}) begin
        r.rem = r.rem - {1'b0, r.dv};
        r.acc[0] = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    st0.rem = '0;
    st0.acc = num[31] ? (32'd0 - num) : num;
    st0.dv = den[31] ? (32'd0 - den) : den;
    st0.neg = num[31] ^ den[31];
    st0.zero = (den == 32'd0);
  end

  for (genvar s = 0; s < lrni_pkg::DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) stg[s] <= div_step(st0);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) stg[s] <= div_step(stg[s-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (stg[lrni_pkg::DIV_STAGES-1].zero) begin
        quo <= '0;
      end else if (stg[lrni_pkg::DIV_STAGES-1].neg) begin
        quo <= 32'd0 - stg[lrni_pkg::DIV_STAGES-1].acc;
      end else begin
        quo <= stg[lrni_pkg::DIV_STAGES-1].acc;
      end
    end
  end

endmodule

FILE: hdl/lrni_sqrt.sv
module lrni_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] val,
  output logic [15:0] root
);

  lrni_pkg::sq_st_t st0;
  lrni_pkg::sq_st_t stg [lrni_pkg::SQ_STAGES];

  function automatic lrni_pkg::sq_st_t sq_step(input lrni_pkg::sq_st_t s);
    lrni_pkg::sq_st_t r;
    logic [19:0] trial;
    r = s;
    for (int k = 0; k < 2; k++) begin
      r.rem = {r.rem[17:0], r.val[31:30]};
      r.val = {r.val[29:0], 2'b00};
      trial = {2'b00, r.root, 2'b01};
      if (r.rem >= trial) begin
        r.rem = r.rem - trial;
        r.root = {r.root[14:0], 1'b1};
      end else begin
        r.root = {r.root[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_comb begin
    st0.rem = '0;
    st0.root = '0;
    st0.val = val;
  end

  for (genvar s = 0; s < lrni_pkg::SQ_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) stg[s] <= sq_step(st0);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) stg[s] <= sq_step(stg[s-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) root <= stg[lrni_pkg::SQ_STAGES-1].root;
  end

endmodule

FILE: hdl/line_rect_nearest_intersection_core.sv
// Nearest crossing of a 16.16 line with the edges of a rectangle.
// The input channel (in_valid, in_stall) carries one request per unstalled
// cycle: the steep flag, the reference point, slope, offset and box bounds.
// The output channel (out_valid, out_stall) returns one result per request,
// in request order: found, hit_x, hit_y, distance and edge_mask.
// Throughput is one request per cycle while no result is stalled. Most
// of the pipeline depth lies in the two pipelined dividers (two quotient
// bits per stage) and the four pipelined square root units (two root bits
// per stage).
// When the receiver stalls a pending result, the whole pipeline holds and
// in_stall is raised in the same cycle, so no request is lost or repeated.
// A synchronous reset clears all valid bits; the data registers are not
// reset, and a request may be offered in the first cycle after reset.
module line_rect_nearest_intersection_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               steep,
  input  logic signed [31:0] from_x,
  input  logic signed [31:0] from_y,
  input  logic signed [31:0] slope,
  input  logic signed [31:0] line_offset,
  input  logic signed [31:0] box_left,
  input  logic signed [31:0] box_top,
  input  logic signed [31:0] box_right,
  input  logic signed [31:0] box_bottom,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic        [15:0] distance,
  output logic        [3:0]  edge_mask
);

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic        v1;
  logic        s1_steep;
  logic [31:0] s1_fx, s1_fy, s1_slope, s1_off;
  logic [31:0] s1_left, s1_top, s1_right, s1_bottom;
  logic [31:0] s1_p0, s1_p1, s1_n0, s1_n1;

  logic [31:0] a0, a1, b0, b1;
  logic [31:0] prod0, prod1;

  always_comb begin
    a0 = steep ? box_top : box_left;
    a1 = steep ? box_bottom : box_right;
    b0 = steep ? box_left : box_top;
    b1 = steep ? box_right : box_bottom;
    prod0 = slope * a0;
    prod1 = slope * a1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_steep <= steep;
      s1_fx <= from_x;
      s1_fy <= from_y;
      s1_slope <= slope;
      s1_off <= line_offset;
      s1_left <= box_left;
      s1_top <= box_top;
      s1_right <= box_right;
      s1_bottom <= box_bottom;
      s1_p0 <= prod0;
      s1_p1 <= prod1;
      s1_n0 <= {b0[15:0] - line_offset[15:0], 16'd0};
      s1_n1 <= {b1[15:0] - line_offset[15:0], 16'd0};
    end
  end

  logic [31:0] q0, q1;

  lrni_div u_div0 (.clk(clk), .en(en), .num(s1_n0), .den(s1_slope), .quo(q0));
  lrni_div u_div1 (.clk(clk), .en(en), .num(s1_n1), .den(s1_slope), .quo(q1));

  lrni_pkg::side_t side_in;
  lrni_pkg::side_t side_dl [lrni_pkg::DIV_LAT];
  logic [lrni_pkg::DIV_LAT-1:0] v_dl;

  always_comb begin
    side_in.steep = s1_steep;
    side_in.fx = s1_fx;
    side_in.fy = s1_fy;
    side_in.left = s1_left;
    side_in.top = s1_top;
    side_in.right = s1_right;
    side_in.bottom = s1_bottom;
    side_in.m0 = ($signed(s1_p0) >>> 16) + $signed(s1_off);
    side_in.m1 = ($signed(s1_p1) >>> 16) + $signed(s1_off);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dl <= '0;
    end else if (en) begin
      v_dl <= {v_dl[lrni_pkg::DIV_LAT-2:0], v1};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_dl[0] <= side_in;
      for (int i = 1; i < lrni_pkg::DIV_LAT; i++) side_dl[i] <= side_dl[i-1];
    end
  end

  lrni_pkg::side_t sd;
  lrni_pkg::cand_t cand;
  logic [3:0][31:0] dx, dy;

  assign sd = side_dl[lrni_pkg::DIV_LAT-1];

  always_comb begin
    cand.cy[0] = sd.top;
    cand.cy[1] = sd.bottom;
    cand.cx[2] = sd.left;
    cand.cx[3] = sd.right;
    if (!sd.steep) begin
      cand.cx[0] = q0;
      cand.cx[1] = q1;
      cand.cy[2] = sd.m0;
      cand.cy[3] = sd.m1;
    end else begin
      cand.cy[2] = q0;
      cand.cy[3] = q1;
      cand.cx[0] = sd.m0;
      cand.cx[1] = sd.m1;
    end
    cand.mask[0] = ($signed(sd.left) < $signed(cand.cx[0])) &&
                   ($signed(cand.cx[0]) < $signed(sd.right));
    cand.mask[1] = ($signed(sd.left) < $signed(cand.cx[1])) &&
                   ($signed(cand.cx[1]) < $signed(sd.right));
    cand.mask[2] = ($signed(sd.top) < $signed(cand.cy[2])) &&
                   ($signed(cand.cy[2]) < $signed(sd.bottom));
    cand.mask[3] = ($signed(sd.top) < $signed(cand.cy[3])) &&
                   ($signed(cand.cy[3]) < $signed(sd.bottom));
    for (int i = 0; i < 4; i++) begin
      dx[i] = sd.fx - cand.cx[i];
      dy[i] = sd.fy - cand.cy[i];
    end
  end

  logic v2, v3, v4;
  lrni_pkg::cand_t c2, c3, c4;
  logic [3:0][31:0] dx2, dy2, sqx3, sqy3, sum4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v2 <= v_dl[lrni_pkg::DIV_LAT-1];
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= cand;
      dx2 <= dx;
      dy2 <= dy;
      c3 <= c2;
      for (int i = 0; i < 4; i++) begin
        sqx3[i] <= dx2[i] * dx2[i];
        sqy3[i] <= dy2[i] * dy2[i];
      end
      c4 <= c3;
      for (int i = 0; i < 4; i++) sum4[i] <= sqx3[i] + sqy3[i];
    end
  end

  logic [15:0] root [4];

  for (genvar g = 0; g < 4; g++) begin : g_root
    lrni_sqrt u_sqrt (.clk(clk), .en(en), .val(sum4[g]), .root(root[g]));
  end

  lrni_pkg::cand_t c_dl [lrni_pkg::SQ_LAT];
  logic [lrni_pkg::SQ_LAT-1:0] vs_dl;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs_dl <= '0;
    end else if (en) begin
      vs_dl <= {vs_dl[lrni_pkg::SQ_LAT-2:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_dl[0] <= c4;
      for (int i = 1; i < lrni_pkg::SQ_LAT; i++) c_dl[i] <= c_dl[i-1];
    end
  end

  lrni_pkg::cand_t cf;
  logic        any;
  logic [15:0] best;
  logic [31:0] hx, hy;

  assign cf = c_dl[lrni_pkg::SQ_LAT-1];

  always_comb begin
    any = 1'b0;
    best = '0;
    hx = '0;
    hy = '0;
    for (int i = 0; i < 4; i++) begin
      if (cf.mask[i] && (!any || root[i] < best)) begin
        any = 1'b1;
        best = root[i];
        hx = cf.cx[i];
        hy = cf.cy[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs_dl[lrni_pkg::SQ_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      found <= any;
      hit_x <= hx;
      hit_y <= hy;
      distance <= best;
      edge_mask <= cf.mask;
    end
  end

endmodule

FILE: hdl/lrni_checker.sv
module lrni_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        found,
  input logic [31:0] hit_x,
  input logic [31:0] hit_y,
  input logic [15:0] distance,
  input logic [3:0]  edge_mask
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result was dropped.");

  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == (edge_mask != 4'd0)))
    else $error("Found flag disagrees with the edge mask.");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> hit_x == 32'd0 && hit_y == 32'd0 && distance == 16'd0)
    else $error("Empty result carries nonzero fields.");

  a_back: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("Input stall does not follow the output stall.");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("Result shown right after reset.");

endmodule

bind line_rect_nearest_intersection_core lrni_checker u_lrni_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .found(found),
  .hit_x(hit_x),
  .hit_y(hit_y),
  .distance(distance),
  .edge_mask(edge_mask)
);
